// ----- hw/rtl/safd_pkg.sv -----
package safd_pkg;

  // field and datapath widths
  localparam int PosW      = 32;
  localparam int DiffW     = 33;
  localparam int RestInW   = 16;
  localparam int WeightW   = 16;
  localparam int CfgW      = 32;
  localparam int RestShift = 8;
  localparam int RestW     = RestInW + CfgW - RestShift;
  localparam int SqW       = 2 * DiffW;
  localparam int RadW      = 68;
  localparam int RootW     = RadW / 2;
  localparam int RootRemW  = RootW + 2;
  localparam int KW        = RestW;
  localparam int P1W       = KW + WeightW + 1;
  localparam int SplitW    = 17;
  localparam int PpW       = P1W + SplitW;
  localparam int NumW      = P1W + DiffW;
  localparam int DenW      = RootW + 8;
  localparam int QW        = 33;
  localparam int EsqInW    = 28;
  localparam int EsqW      = 2 * EsqInW;
  localparam int EW        = EsqW + WeightW;
  localparam int EShift    = 24;

  localparam int QueueDepthDef = 2;

  // saturation limits
  localparam logic [PosW-1:0] ForceMax  = 32'h7FFF_FFFF;
  localparam logic [PosW-1:0] ForceMin  = 32'h8000_0000;
  localparam logic [CfgW-1:0] EnergyMax = 32'hFFFF_FFFF;

  // register reset values
  localparam logic [WeightW-1:0] WeightRst    = 16'd256;
  localparam logic [CfgW-1:0]    SpringLenRst = 32'd65536;
  localparam logic [CfgW-1:0]    MinDistRst   = 32'd256;

  typedef enum logic [1:0] {
    CFG_WEIGHT     = 2'd0,
    CFG_SPRING_LEN = 2'd1,
    CFG_MIN_DIST   = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic [WeightW-1:0] weight;
    logic [CfgW-1:0]    rest_scale;
    logic [CfgW-1:0]    min_distance;
  } cfg_t;

  // one classified spring item
  typedef struct packed {
    logic [DiffW-1:0] mag_x;
    logic             neg_x;
    logic [DiffW-1:0] mag_y;
    logic             neg_y;
    logic [RestW-1:0] rest;
  } spring_t;

endpackage

// ----- hw/rtl/safd_front.sv -----
module safd_front import safd_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  output logic                   busy,
  input  logic signed [PosW-1:0] in_first_x,
  input  logic signed [PosW-1:0] in_first_y,
  input  logic signed [PosW-1:0] in_second_x,
  input  logic signed [PosW-1:0] in_second_y,
  input  logic [RestInW-1:0]     in_rest_distance,
  input  cfg_t                   cfg,
  input  logic                   q_ready,
  output logic                   push,
  output spring_t                push_item
);

  logic                      accept;
  logic [DiffW-1:0]          dx, dy;
  logic [RestInW+CfgW-1:0]   rest_prod;
  spring_t                   item_nxt, item_r;
  logic                      vld_r, vld_nxt;

  // differences, magnitudes and scaled rest distance
  assign dx = {in_second_x[PosW-1], in_second_x} - {in_first_x[PosW-1], in_first_x};
  assign dy = {in_second_y[PosW-1], in_second_y} - {in_first_y[PosW-1], in_first_y};
  assign rest_prod = (RestInW+CfgW)'(in_rest_distance) * (RestInW+CfgW)'(cfg.rest_scale);

  always_comb begin
    item_nxt.neg_x = dx[DiffW-1];
    item_nxt.mag_x = dx[DiffW-1] ? (~dx + 1'b1) : dx;
    item_nxt.neg_y = dy[DiffW-1];
    item_nxt.mag_y = dy[DiffW-1] ? (~dy + 1'b1) : dy;
    item_nxt.rest  = rest_prod[RestInW+CfgW-1:RestShift];
  end

  // handshake
  assign busy   = vld_r && !q_ready;
  assign accept = start && !busy;
  assign push   = vld_r && q_ready;
  assign push_item = item_r;

  always_comb begin
    if (accept) begin
      vld_nxt = 1'b1;
    end else if (push) begin
      vld_nxt = 1'b0;
    end else begin
      vld_nxt = vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= item_nxt;
    end
  end

endmodule

// ----- hw/rtl/safd_queue.sv -----
module safd_queue import safd_pkg::*; #(
  parameter int Depth = QueueDepthDef
) (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  spring_t wr_item,
  output logic    ready,
  output logic    valid,
  output spring_t rd_item
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  spring_t         mem_r [Depth];
  logic [PtrW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CntW-1:0] count_r;
  logic            pop;

  // the back end takes an item in every cycle that one is there
  assign valid   = count_r != '0;
  assign ready   = count_r != CntW'(Depth);
  assign pop     = valid;
  assign rd_item = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PtrW'(Depth - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PtrW'(Depth - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_item;
    end
  end

endmodule

// ----- hw/rtl/safd_sqrt.sv -----
module safd_sqrt import safd_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_vld,
  input  logic [RadW-1:0]  in_rad,
  input  spring_t          in_item,
  output logic             out_vld,
  output logic [RootW-1:0] out_root,
  output spring_t          out_item
);

  logic                vld_r  [RootW];
  logic [RootRemW-1:0] rem_r  [RootW];
  logic [RootW-1:0]    root_r [RootW];
  logic [RadW-1:0]     rad_r  [RootW];
  spring_t             item_r [RootW];

  logic                vld_in  [RootW];
  logic [RootRemW-1:0] rem_in  [RootW];
  logic [RootW-1:0]    root_in [RootW];
  logic [RadW-1:0]     rad_in  [RootW];
  spring_t             item_in [RootW];
  logic [RootRemW+1:0] cur     [RootW];
  logic [RootRemW+1:0] trial   [RootW];
  logic                ge      [RootW];

  // one root bit per stage, radicand shifted in two bits at a time
  always_comb begin
    for (int s = 0; s < RootW; s++) begin
      if (s == 0) begin
        vld_in[s]  = in_vld;
        rem_in[s]  = '0;
        root_in[s] = '0;
        rad_in[s]  = in_rad;
        item_in[s] = in_item;
      end else begin
        vld_in[s]  = vld_r[s-1];
        rem_in[s]  = rem_r[s-1];
        root_in[s] = root_r[s-1];
        rad_in[s]  = rad_r[s-1];
        item_in[s] = item_r[s-1];
      end
      cur[s]   = {rem_in[s], rad_in[s][RadW-1 -: 2]};
      trial[s] = (RootRemW+2)'({root_in[s], 2'b01});
      ge[s]    = cur[s] >= trial[s];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < RootW; s++) begin
        vld_r[s] <= 1'b0;
      end
    end else begin
      for (int s = 0; s < RootW; s++) begin
        vld_r[s] <= vld_in[s];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int s = 0; s < RootW; s++) begin
      rem_r[s]  <= ge[s] ? RootRemW'(cur[s] - trial[s]) : RootRemW'(cur[s]);
      root_r[s] <= {root_in[s][RootW-2:0], ge[s]};
      rad_r[s]  <= rad_in[s] << 2;
      item_r[s] <= item_in[s];
    end
  end

  assign out_vld  = vld_r[RootW-1];
  assign out_root = root_r[RootW-1];
  assign out_item = item_r[RootW-1];

endmodule

// ----- hw/rtl/safd_div.sv -----
module safd_div import safd_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_vld,
  input  logic [NumW-1:0]        in_num_x,
  input  logic [NumW-1:0]        in_num_y,
  input  logic                   in_neg_x,
  input  logic                   in_neg_y,
  input  logic [DenW-1:0]        in_den,
  input  logic [CfgW-1:0]        in_energy,
  output logic                   out_valid,
  output logic signed [PosW-1:0] out_force_x,
  output logic signed [PosW-1:0] out_force_y,
  output logic [CfgW-1:0]        out_energy
);

  // quotient clamp with sign, rounding toward zero
  function automatic logic [PosW-1:0] sat_force(input logic [QW-1:0] q, input logic ovf,
                                                input logic neg);
    logic [PosW-1:0] r;
    if (!ovf && q == '0) begin
      r = '0;
    end else if (!neg) begin
      r = (ovf || q > {1'b0, ForceMax}) ? ForceMax : q[PosW-1:0];
    end else if (ovf || q > {1'b0, ForceMin}) begin
      r = ForceMin;
    end else begin
      r = ~q[PosW-1:0] + 1'b1;
    end
    return r;
  endfunction

  // pre stage: overflow check and first partial remainder
  logic            pre_vld_r;
  logic            pre_ovfx_r, pre_ovfy_r, pre_negx_r, pre_negy_r;
  logic [DenW-1:0] pre_remx_r, pre_remy_r, pre_den_r;
  logic [QW-1:0]   pre_lowx_r, pre_lowy_r;
  logic [CfgW-1:0] pre_energy_r;
  logic [NumW-1:0] den_top;

  assign den_top = NumW'(in_den) << QW;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pre_vld_r <= 1'b0;
    end else begin
      pre_vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    pre_ovfx_r   <= in_num_x >= den_top;
    pre_ovfy_r   <= in_num_y >= den_top;
    pre_remx_r   <= DenW'(in_num_x >> QW);
    pre_remy_r   <= DenW'(in_num_y >> QW);
    pre_lowx_r   <= in_num_x[QW-1:0];
    pre_lowy_r   <= in_num_y[QW-1:0];
    pre_negx_r   <= in_neg_x;
    pre_negy_r   <= in_neg_y;
    pre_den_r    <= in_den;
    pre_energy_r <= in_energy;
  end

  // restoring stages, one quotient bit per lane and stage
  logic            vld_r    [QW];
  logic [DenW-1:0] remx_r   [QW];
  logic [DenW-1:0] remy_r   [QW];
  logic [QW-1:0]   lowx_r   [QW];
  logic [QW-1:0]   lowy_r   [QW];
  logic [QW-1:0]   qx_r     [QW];
  logic [QW-1:0]   qy_r     [QW];
  logic            ovfx_r   [QW];
  logic            ovfy_r   [QW];
  logic            negx_r   [QW];
  logic            negy_r   [QW];
  logic [DenW-1:0] den_r    [QW];
  logic [CfgW-1:0] energy_r [QW];

  logic            vld_in    [QW];
  logic [DenW-1:0] remx_in   [QW];
  logic [DenW-1:0] remy_in   [QW];
  logic [QW-1:0]   lowx_in   [QW];
  logic [QW-1:0]   lowy_in   [QW];
  logic [QW-1:0]   qx_in     [QW];
  logic [QW-1:0]   qy_in     [QW];
  logic            ovfx_in   [QW];
  logic            ovfy_in   [QW];
  logic            negx_in   [QW];
  logic            negy_in   [QW];
  logic [DenW-1:0] den_in    [QW];
  logic [CfgW-1:0] energy_in [QW];
  logic [DenW:0]   curx      [QW];
  logic [DenW:0]   cury      [QW];
  logic            gex       [QW];
  logic            gey       [QW];

  always_comb begin
    for (int s = 0; s < QW; s++) begin
      if (s == 0) begin
        vld_in[s]    = pre_vld_r;
        remx_in[s]   = pre_remx_r;
        remy_in[s]   = pre_remy_r;
        lowx_in[s]   = pre_lowx_r;
        lowy_in[s]   = pre_lowy_r;
        qx_in[s]     = '0;
        qy_in[s]     = '0;
        ovfx_in[s]   = pre_ovfx_r;
        ovfy_in[s]   = pre_ovfy_r;
        negx_in[s]   = pre_negx_r;
        negy_in[s]   = pre_negy_r;
        den_in[s]    = pre_den_r;
        energy_in[s] = pre_energy_r;
      end else begin
        vld_in[s]    = vld_r[s-1];
        remx_in[s]   = remx_r[s-1];
        remy_in[s]   = remy_r[s-1];
        lowx_in[s]   = lowx_r[s-1];
        lowy_in[s]   = lowy_r[s-1];
        qx_in[s]     = qx_r[s-1];
        qy_in[s]     = qy_r[s-1];
        ovfx_in[s]   = ovfx_r[s-1];
        ovfy_in[s]   = ovfy_r[s-1];
        negx_in[s]   = negx_r[s-1];
        negy_in[s]   = negy_r[s-1];
        den_in[s]    = den_r[s-1];
        energy_in[s] = energy_r[s-1];
      end
      curx[s] = {remx_in[s], lowx_in[s][QW-1]};
      cury[s] = {remy_in[s], lowy_in[s][QW-1]};
      gex[s]  = curx[s] >= {1'b0, den_in[s]};
      gey[s]  = cury[s] >= {1'b0, den_in[s]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < QW; s++) begin
        vld_r[s] <= 1'b0;
      end
    end else begin
      for (int s = 0; s < QW; s++) begin
        vld_r[s] <= vld_in[s];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int s = 0; s < QW; s++) begin
      remx_r[s]   <= gex[s] ? DenW'(curx[s] - {1'b0, den_in[s]}) : DenW'(curx[s]);
      remy_r[s]   <= gey[s] ? DenW'(cury[s] - {1'b0, den_in[s]}) : DenW'(cury[s]);
      lowx_r[s]   <= lowx_in[s] << 1;
      lowy_r[s]   <= lowy_in[s] << 1;
      qx_r[s]     <= {qx_in[s][QW-2:0], gex[s]};
      qy_r[s]     <= {qy_in[s][QW-2:0], gey[s]};
      ovfx_r[s]   <= ovfx_in[s];
      ovfy_r[s]   <= ovfy_in[s];
      negx_r[s]   <= negx_in[s];
      negy_r[s]   <= negy_in[s];
      den_r[s]    <= den_in[s];
      energy_r[s] <= energy_in[s];
    end
  end

  // output register
  logic            out_vld_r;
  logic [PosW-1:0] fx_r, fy_r;
  logic [CfgW-1:0] en_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= vld_r[QW-1];
    end
  end

  always_ff @(posedge clk) begin
    fx_r <= sat_force(qx_r[QW-1], ovfx_r[QW-1], negx_r[QW-1]);
    fy_r <= sat_force(qy_r[QW-1], ovfy_r[QW-1], negy_r[QW-1]);
    en_r <= energy_r[QW-1];
  end

  assign out_valid   = out_vld_r;
  assign out_force_x = fx_r;
  assign out_force_y = fy_r;
  assign out_energy  = en_r;

endmodule

// ----- hw/rtl/safd_back.sv -----
module safd_back import safd_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_vld,
  input  spring_t                in_item,
  input  cfg_t                   cfg,
  output logic                   out_valid,
  output logic signed [PosW-1:0] out_force_x,
  output logic signed [PosW-1:0] out_force_y,
  output logic [CfgW-1:0]        out_energy
);

  localparam int SubW = RestW + 1;

  // squares of the components
  logic          sq_vld_r;
  logic [SqW-1:0] sqx_r, sqy_r;
  spring_t       sq_item_r;

  always_ff @(posedge clk) begin
    sqx_r     <= SqW'(in_item.mag_x) * SqW'(in_item.mag_x);
    sqy_r     <= SqW'(in_item.mag_y) * SqW'(in_item.mag_y);
    sq_item_r <= in_item;
  end

  // sum of squares
  logic            rad_vld_r;
  logic [RadW-1:0] rad_r;
  spring_t         rad_item_r;

  always_ff @(posedge clk) begin
    rad_r      <= RadW'(sqx_r) + RadW'(sqy_r);
    rad_item_r <= sq_item_r;
  end

  // length
  logic             rt_vld;
  logic [RootW-1:0] rt_root;
  spring_t          rt_item;

  safd_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (rad_vld_r),
    .in_rad   (rad_r),
    .in_item  (rad_item_r),
    .out_vld  (rt_vld),
    .out_root (rt_root),
    .out_item (rt_item)
  );

  // clamp and differences to the rest distance
  logic [RootW-1:0] mn, clamped;
  logic [SubW-1:0]  fdiff, ediff;
  logic             cl_vld_r, cl_kneg_r;
  logic [RootW-1:0] cl_c_r;
  logic [KW-1:0]    cl_k_r, cl_em_r;
  spring_t          cl_item_r;

  always_comb begin
    mn      = (cfg.min_distance == '0) ? RootW'(1) : RootW'(cfg.min_distance);
    clamped = (rt_root < mn) ? mn : rt_root;
    fdiff   = SubW'(clamped) - SubW'(rt_item.rest);
    ediff   = SubW'(rt_root) - SubW'(rt_item.rest);
  end

  always_ff @(posedge clk) begin
    cl_c_r    <= clamped;
    cl_kneg_r <= fdiff[SubW-1];
    cl_k_r    <= fdiff[SubW-1] ? KW'(-fdiff) : KW'(fdiff);
    cl_em_r   <= ediff[SubW-1] ? KW'(-ediff) : KW'(ediff);
    cl_item_r <= rt_item;
  end

  // 2*weight*k and the energy square
  logic             m1_vld_r, m1_kneg_r, m1_ebig_r;
  logic [P1W-1:0]   m1_p1_r;
  logic [EsqW-1:0]  m1_esq_r;
  logic [RootW-1:0] m1_c_r;
  spring_t          m1_item_r;

  always_ff @(posedge clk) begin
    m1_p1_r   <= P1W'(cl_k_r) * P1W'({cfg.weight, 1'b0});
    m1_esq_r  <= EsqW'(cl_em_r[EsqInW-1:0]) * EsqW'(cl_em_r[EsqInW-1:0]);
    m1_ebig_r <= |cl_em_r[KW-1:EsqInW];
    m1_kneg_r <= cl_kneg_r;
    m1_c_r    <= cl_c_r;
    m1_item_r <= cl_item_r;
  end

  // low partial products and the weighted energy
  logic             m2_vld_r, m2_kneg_r, m2_ebig_r;
  logic [PpW-1:0]   m2_plx_r, m2_ply_r;
  logic [P1W-1:0]   m2_p1_r;
  logic [EW-1:0]    m2_e_r;
  logic [RootW-1:0] m2_c_r;
  spring_t          m2_item_r;

  always_ff @(posedge clk) begin
    m2_plx_r  <= PpW'(m1_p1_r) * PpW'(m1_item_r.mag_x[SplitW-1:0]);
    m2_ply_r  <= PpW'(m1_p1_r) * PpW'(m1_item_r.mag_y[SplitW-1:0]);
    m2_e_r    <= EW'(m1_esq_r) * EW'(cfg.weight);
    m2_p1_r   <= m1_p1_r;
    m2_ebig_r <= m1_ebig_r;
    m2_kneg_r <= m1_kneg_r;
    m2_c_r    <= m1_c_r;
    m2_item_r <= m1_item_r;
  end

  // high partial products and energy saturation
  logic             m3_vld_r, m3_kneg_r;
  logic [PpW-1:0]   m3_plx_r, m3_ply_r, m3_phx_r, m3_phy_r;
  logic [CfgW-1:0]  m3_energy_r, energy_nxt;
  logic [RootW-1:0] m3_c_r;
  spring_t          m3_item_r;

  always_comb begin
    if (m2_ebig_r && cfg.weight != '0) begin
      energy_nxt = EnergyMax;
    end else if (|m2_e_r[EW-1:EShift+CfgW]) begin
      energy_nxt = EnergyMax;
    end else begin
      energy_nxt = m2_e_r[EShift +: CfgW];
    end
  end

  always_ff @(posedge clk) begin
    m3_phx_r    <= PpW'(m2_p1_r) * PpW'(m2_item_r.mag_x[DiffW-1:SplitW]);
    m3_phy_r    <= PpW'(m2_p1_r) * PpW'(m2_item_r.mag_y[DiffW-1:SplitW]);
    m3_plx_r    <= m2_plx_r;
    m3_ply_r    <= m2_ply_r;
    m3_energy_r <= energy_nxt;
    m3_kneg_r   <= m2_kneg_r;
    m3_c_r      <= m2_c_r;
    m3_item_r   <= m2_item_r;
  end

  // full numerators and signs for the divider
  logic            m4_vld_r, m4_negx_r, m4_negy_r;
  logic [NumW-1:0] m4_numx_r, m4_numy_r;
  logic [DenW-1:0] m4_den_r;
  logic [CfgW-1:0] m4_energy_r;

  always_ff @(posedge clk) begin
    m4_numx_r   <= NumW'(m3_plx_r) + (NumW'(m3_phx_r) << SplitW);
    m4_numy_r   <= NumW'(m3_ply_r) + (NumW'(m3_phy_r) << SplitW);
    m4_den_r    <= {m3_c_r, 8'b0};
    m4_negx_r   <= m3_item_r.neg_x ^ m3_kneg_r;
    m4_negy_r   <= m3_item_r.neg_y ^ m3_kneg_r;
    m4_energy_r <= m3_energy_r;
  end

  // valid chain
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_vld_r  <= 1'b0;
      rad_vld_r <= 1'b0;
      cl_vld_r  <= 1'b0;
      m1_vld_r  <= 1'b0;
      m2_vld_r  <= 1'b0;
      m3_vld_r  <= 1'b0;
      m4_vld_r  <= 1'b0;
    end else begin
      sq_vld_r  <= in_vld;
      rad_vld_r <= sq_vld_r;
      cl_vld_r  <= rt_vld;
      m1_vld_r  <= cl_vld_r;
      m2_vld_r  <= m1_vld_r;
      m3_vld_r  <= m2_vld_r;
      m4_vld_r  <= m3_vld_r;
    end
  end

  safd_div u_div (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_vld      (m4_vld_r),
    .in_num_x    (m4_numx_r),
    .in_num_y    (m4_numy_r),
    .in_neg_x    (m4_negx_r),
    .in_neg_y    (m4_negy_r),
    .in_den      (m4_den_r),
    .in_energy   (m4_energy_r),
    .out_valid   (out_valid),
    .out_force_x (out_force_x),
    .out_force_y (out_force_y),
    .out_energy  (out_energy)
  );

endmodule

// ----- hw/rtl/spring_attraction_force_2d_unit.sv -----
// Spring attraction force, 2D: one spring edge in, one force and energy out.
// Input channel: present the end points and rest distance with start high;
// the item is taken at a clock edge where start is high and busy is low.
// busy only rises if the front register cannot hand over to the queue, which
// the back end drains every cycle, so one item can be taken in every cycle.
// Results: out_valid is high for exactly one cycle with out_force_x,
// out_force_y and out_energy; there is no back pressure on this side.
// Path to out_valid from the accepting edge: the front register, the queue,
// the square and sum stages, the 34-stage square root pipeline, the clamp
// and multiply stages, then the divider's input register, its 33 quotient
// stages and its output register.
// Throughput: one item per cycle.
// Configuration: cfg_valid with cfg_index and cfg_data; cfg_ready is always
// high. Indices 0..2 write weight, rest scale and min_distance; others
// are dropped. Write only while no item is in flight.
// Reset (rst_n low, synchronous) empties the pipeline and the queue and sets
// weight 1.0, rest scale 1.0 and min_distance 256.
module spring_attraction_force_2d_unit import safd_pkg::*; #(
  parameter int QueueDepth = QueueDepthDef
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  output logic                   busy,
  input  logic signed [PosW-1:0] in_first_x,
  input  logic signed [PosW-1:0] in_first_y,
  input  logic signed [PosW-1:0] in_second_x,
  input  logic signed [PosW-1:0] in_second_y,
  input  logic [RestInW-1:0]     in_rest_distance,
  output logic                   out_valid,
  output logic signed [PosW-1:0] out_force_x,
  output logic signed [PosW-1:0] out_force_y,
  output logic [CfgW-1:0]        out_energy,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [1:0]             cfg_index,
  input  logic [CfgW-1:0]        cfg_data
);

  localparam int ResultDelay = 78;

  cfg_t    cfg_r;
  logic    q_ready, q_valid, push;
  spring_t push_item, pop_item;

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.weight       <= WeightRst;
      cfg_r.rest_scale   <= SpringLenRst;
      cfg_r.min_distance <= MinDistRst;
    end else if (cfg_valid) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_WEIGHT:     cfg_r.weight       <= cfg_data[WeightW-1:0];
        CFG_SPRING_LEN: cfg_r.rest_scale   <= cfg_data;
        CFG_MIN_DIST:   cfg_r.min_distance <= cfg_data;
        default: ;
      endcase
    end
  end

  safd_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_first_x       (in_first_x),
    .in_first_y       (in_first_y),
    .in_second_x      (in_second_x),
    .in_second_y      (in_second_y),
    .in_rest_distance (in_rest_distance),
    .cfg              (cfg_r),
    .q_ready          (q_ready),
    .push             (push),
    .push_item        (push_item)
  );

  safd_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .wr_item (push_item),
    .ready   (q_ready),
    .valid   (q_valid),
    .rd_item (pop_item)
  );

  safd_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_vld      (q_valid),
    .in_item     (pop_item),
    .cfg         (cfg_r),
    .out_valid   (out_valid),
    .out_force_x (out_force_x),
    .out_force_y (out_force_y),
    .out_energy  (out_energy)
  );

  // the back end never stalls, so the front never holds off an item
  a_no_stall: assert property (@(posedge clk) disable iff (!rst_n) !busy)
    else $error("front stalled");

  // every accepted item gives a result after the fixed latency
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##ResultDelay out_valid)
    else $error("result missing");

  // no result without an item accepted at the matching edge
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, ResultDelay))
    else $error("unexpected result");

endmodule

// ----- test/spring_force_checker.sv -----
module spring_force_checker import safd_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  logic                   busy,
  input  logic signed [PosW-1:0] in_first_x,
  input  logic signed [PosW-1:0] in_first_y,
  input  logic signed [PosW-1:0] in_second_x,
  input  logic signed [PosW-1:0] in_second_y,
  input  logic [RestInW-1:0]     in_rest_distance,
  input  logic                   out_valid,
  input  logic signed [PosW-1:0] out_force_x,
  input  logic signed [PosW-1:0] out_force_y,
  input  logic [CfgW-1:0]        out_energy,
  input  logic                   cfg_valid,
  input  logic                   cfg_ready,
  input  logic [1:0]             cfg_index,
  input  logic [CfgW-1:0]        cfg_data,
  output int                     fail_count,
  output int                     pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [PosW-1:0] force_x;
    logic [PosW-1:0] force_y;
    logic [CfgW-1:0] energy;
  } spring_result_t;

  logic [WeightW-1:0] cur_weight;
  logic [CfgW-1:0]    cur_spring_len;
  logic [CfgW-1:0]    cur_min_dist;
  spring_result_t     expected_forces[$];

  // one force component, rounded toward zero and saturated
  function automatic logic [PosW-1:0] force_part(logic signed [33:0] delta, logic [127:0] k,
                                                 logic kneg, logic [127:0] denom);
    logic [127:0] mag;
    logic [127:0] quot;
    logic         neg;
    mag  = (delta < 0) ? 128'(-delta) : 128'(delta);
    quot = (mag * 128'(cur_weight) * 128'd2 * k) / denom;
    neg  = (delta < 0) != kneg;
    if (quot == 0) return '0;
    if (!neg) return (quot > 128'h7FFF_FFFF) ? ForceMax : quot[31:0];
    if (quot > 128'h8000_0000) return ForceMin;
    return 32'(-quot[31:0]);
  endfunction

  function automatic spring_result_t predict_spring(
      logic signed [PosW-1:0] fx, logic signed [PosW-1:0] fy,
      logic signed [PosW-1:0] sx, logic signed [PosW-1:0] sy, logic [RestInW-1:0] rd);
    logic signed [33:0] dx;
    logic signed [33:0] dy;
    logic [127:0] ax, ay, sq, cand, len, rest, em, e, mn, clamped, k;
    logic         kneg;
    spring_result_t r;
    dx = sx - fx;
    dy = sy - fy;
    ax = (dx < 0) ? 128'(-dx) : 128'(dx);
    ay = (dy < 0) ? 128'(-dy) : 128'(dy);
    sq = ax * ax + ay * ay;
    // exact integer square root, bit by bit
    len = '0;
    for (int b = 33; b >= 0; b--) begin
      cand = len | (128'd1 << b);
      if (cand * cand <= sq) len = cand;
    end
    rest = (128'(rd) * 128'(cur_spring_len)) >> 8;
    // energy uses the unclamped length
    em = (len >= rest) ? len - rest : rest - len;
    e  = (em * 128'(cur_weight) * em) >> EShift;
    r.energy = (e > 128'hFFFF_FFFF) ? EnergyMax : e[31:0];
    // force uses the length clamped up to the minimum
    mn      = (cur_min_dist == 0) ? 128'd1 : 128'(cur_min_dist);
    clamped = (len < mn) ? mn : len;
    kneg    = clamped < rest;
    k       = kneg ? rest - clamped : clamped - rest;
    r.force_x = force_part(dx, k, kneg, clamped << 8);
    r.force_y = force_part(dy, k, kneg, clamped << 8);
    return r;
  endfunction

  assign pending = expected_forces.size();

  always @(posedge clk) begin
    spring_result_t want;
    if (!rst_n) begin
      cur_weight     <= WeightRst;
      cur_spring_len <= SpringLenRst;
      cur_min_dist   <= MinDistRst;
      expected_forces.delete();
      fail_count = 0;
    end else begin
      // register writes
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_WEIGHT:     cur_weight     <= cfg_data[WeightW-1:0];
          CFG_SPRING_LEN: cur_spring_len <= cfg_data;
          CFG_MIN_DIST:   cur_min_dist   <= cfg_data;
          default: ;
        endcase
      end
      // accepted item
      if (start && !busy)
        expected_forces.push_back(predict_spring(in_first_x, in_first_y, in_second_x,
                                                 in_second_y, in_rest_distance));
      // result compare
      if (out_valid) begin
        if (expected_forces.size() == 0) begin
          $error("result with no item waiting");
          fail_count++;
        end else begin
          want = expected_forces.pop_front();
          if (out_force_x !== want.force_x) begin
            $error("force_x expected %h actual %h", want.force_x, out_force_x);
            fail_count++;
          end
          if (out_force_y !== want.force_y) begin
            $error("force_y expected %h actual %h", want.force_y, out_force_y);
            fail_count++;
          end
          if (out_energy !== want.energy) begin
            $error("energy expected %h actual %h", want.energy, out_energy);
            fail_count++;
          end
        end
      end
    end
  end

endmodule

// ----- test/tb_spring_attraction_force_2d_unit.sv -----
module tb_spring_attraction_force_2d_unit import safd_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] CfgUnused = 2'd3;
  localparam int Latency = 77;
  localparam int CycleLimit = 600000;

  logic                   clk;
  logic                   rst_n;
  logic                   start;
  logic                   busy;
  logic signed [PosW-1:0] in_first_x, in_first_y, in_second_x, in_second_y;
  logic [RestInW-1:0]     in_rest_distance;
  logic                   out_valid;
  logic signed [PosW-1:0] out_force_x, out_force_y;
  logic [CfgW-1:0]        out_energy;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [1:0]             cfg_index;
  logic [CfgW-1:0]        cfg_data;
  int                     fail_count;
  int                     pending;
  int                     cycles = 0;
  bit                     no_gaps;

  spring_attraction_force_2d_unit dut (.*);

  spring_force_checker checker_i (.*);

  // clock
  always begin
    clk = 1'b0; #2;
    clk = 1'b1; #2;
  end

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic send_item(logic [31:0] fx, logic [31:0] fy, logic [31:0] sx,
                           logic [31:0] sy, logic [15:0] rd);
    int gap;
    start            <= 1'b1;
    in_first_x       <= fx;
    in_first_y       <= fy;
    in_second_x      <= sx;
    in_second_y      <= sy;
    in_rest_distance <= rd;
    @(posedge clk iff !busy);
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // hold off until every item has come out, then let the pipe settle
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
    repeat (Latency + 5) @(posedge clk);
  endtask

  // one write, then cfg_valid low again before the next
  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk iff cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_regs(logic [15:0] w, logic [31:0] sl, logic [31:0] md);
    write_reg(CFG_WEIGHT, {16'd0, w});
    write_reg(CFG_SPRING_LEN, sl);
    write_reg(CFG_MIN_DIST, md);
    @(posedge clk);
  endtask

  // random edge: full range, or nearby points for useful magnitudes
  task automatic random_item();
    logic [31:0] cx, cy;
    int          span;
    if ($urandom_range(0, 3) == 0) begin
      send_item($urandom, $urandom, $urandom, $urandom, 16'($urandom));
    end else begin
      cx   = $urandom;
      cy   = $urandom;
      span = 1 << $urandom_range(4, 22);
      send_item(cx, cy, cx + $urandom_range(0, span) - span / 2,
                cy + $urandom_range(0, span) - span / 2, 16'($urandom_range(0, 2048)));
    end
  endtask

  initial begin
    no_gaps          = 1'b0;
    rst_n            = 1'b0;
    start            = 1'b0;
    in_first_x       = '0;
    in_first_y       = '0;
    in_second_x      = '0;
    in_second_y      = '0;
    in_rest_distance = '0;
    cfg_valid        = 1'b0;
    cfg_index        = CFG_WEIGHT;
    cfg_data         = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed edges at reset settings
    send_item(32'h0001_0000, 32'h0002_0000, 32'h0001_0000, 32'h0002_0000, 16'h0100);
    send_item(32'h0, 32'h0, 32'h0, 32'h0, 16'h0);
    send_item(32'h0, 32'h0, 32'h0003_0000, 32'h0004_0000, 16'h0);
    send_item(32'h0, 32'h0, 32'h0003_0000, 32'h0004_0000, 16'hFFFF);
    send_item(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'h0);
    send_item(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 16'hFFFF);
    send_item(32'h7FFF_FFFF, 32'h0, 32'h8000_0000, 32'h0, 16'h0100);
    send_item(32'h0, 32'h0, 32'h0, 32'h0000_0010, 16'h0);
    send_item(32'hFFFF_FFFF, 32'h0, 32'h0, 32'hFFFF_FFFF, 16'h0001);
    drain();

    // unused index is ignored; zero minimum and extreme registers
    write_reg(CfgUnused, 32'hDEAD_BEEF);
    set_regs(16'hFFFF, 32'hFFFF_FFFF, 32'h0);
    send_item(32'h0, 32'h0, 32'h0, 32'h0, 16'hFFFF);
    send_item(32'h0, 32'h0, 32'h0, 32'h1, 16'h0);
    send_item(32'h8000_0000, 32'h0, 32'h7FFF_FFFF, 32'h0, 16'hFFFF);
    send_item(32'h1234_5678, 32'h9ABC_DEF0, 32'h1234_5679, 32'h9ABC_DEF0, 16'h0001);
    drain();
    set_regs(16'h0, 32'h0, 32'hFFFF_FFFF);
    send_item(32'h0, 32'h0, 32'h0005_0000, 32'h0, 16'h0100);
    send_item(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'hFFFF);
    drain();
    set_regs(16'h0001, 32'h0001_0000, 32'h1);
    send_item(32'h0, 32'h0, 32'h0, 32'h1, 16'h0);
    send_item(32'h0, 32'h0, 32'h1, 32'h1, 16'h0001);
    drain();

    // random phases across several register settings
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: set_regs(WeightRst, SpringLenRst, MinDistRst);
        1: set_regs(16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        2: set_regs(16'h0, 32'h0, 32'h1);
        3: set_regs(16'h0001, 32'h0000_0001, 32'h0);
        default: set_regs(16'($urandom), $urandom_range(0, 32'h0004_0000),
                          $urandom_range(1, 32'h0010_0000));
      endcase
      no_gaps = (ph == 4);
      for (int n = 0; n < 222; n++) begin
        random_item();
        if (ph == 5 && n == 100) drain();
      end
      drain();
    end

    if (fail_count == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
hw/rtl/safd_pkg.sv
hw/rtl/safd_front.sv
hw/rtl/safd_queue.sv
hw/rtl/safd_sqrt.sv
hw/rtl/safd_div.sv
hw/rtl/safd_back.sv
hw/rtl/spring_attraction_force_2d_unit.sv
test/spring_force_checker.sv
test/tb_spring_attraction_force_2d_unit.sv
